// ----- design/dtc_pkg.sv -----
// Shared types and constants for the debounced tap classifier.
package dtc_pkg;

    localparam int CFG_WIDTH      = 16;
    localparam int CFG_ADDR_WIDTH = 1;
    localparam int STAMP_WIDTH    = 32;
    localparam int IN_TDATA_WIDTH = 40;
    localparam int OUT_TDATA_WIDTH = 8;

    localparam logic [CFG_ADDR_WIDTH-1:0] REG_DEBOUNCE = 1'b0;
    localparam logic [CFG_ADDR_WIDTH-1:0] REG_LONG_TAP = 1'b1;

    localparam logic [CFG_WIDTH-1:0] DEBOUNCE_RESET = 16'd50;
    localparam logic [CFG_WIDTH-1:0] LONG_TAP_RESET = 16'd1000;

    typedef struct packed {
        logic pressed;
        logic short_tap;
        logic long_tap;
    } result_t;

endpackage

// ----- design/debounced_tap_classifier.sv -----
// Debounced tap classifier: turns timestamped touch polls into level and tap flags.
//
// Input stream s_*: one poll per item (raw level, millisecond timestamp and
// requests to take the pending short and long tap flags). Output stream m_*:
// one result per poll (accepted level, short tap flag, long tap flag), in order.
// Configuration: write cfg_wdata to register cfg_addr while cfg_we is high;
// 0 sets the debounce time, 1 the long tap time, both in milliseconds.
// Write configuration only while no poll is in flight.
// Throughput: one poll per cycle while m_tready is high; the state update is one subtract-and-compare
// pass between the input handshake and the output register.
// Results are registered in the output register, or first in the skid stage.
// When m_tready is low the output register holds its item and a skid stage
// takes one more poll; s_tready then drops until the output moves again.
// Reset clears the level, the flags, the stored timestamps and both stream
// stages, and loads debounce 50 ms and long tap 1000 ms.
module debounced_tap_classifier #(
    parameter int TIME_WIDTH = 32
) (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    cfg_we,
    input  logic [dtc_pkg::CFG_ADDR_WIDTH-1:0]      cfg_addr,
    input  logic [dtc_pkg::CFG_WIDTH-1:0]           cfg_wdata,
    input  logic                                    s_tvalid,
    output logic                                    s_tready,
    // raw_level[0], now_ms[32:1], take_short[33], take_long[34], zero pad
    input  logic [dtc_pkg::IN_TDATA_WIDTH-1:0]      s_tdata,
    output logic                                    m_tvalid,
    input  logic                                    m_tready,
    // pressed[0], short_tap[1], long_tap[2], zero pad
    output logic [dtc_pkg::OUT_TDATA_WIDTH-1:0]     m_tdata
);

    dtc_pkg::result_t result;
    dtc_pkg::result_t out_data;
    logic             push;

    assign push = s_tvalid & s_tready;

    dtc_core #(
        .TIME_WIDTH (TIME_WIDTH)
    ) u_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_addr   (cfg_addr),
        .cfg_wdata  (cfg_wdata),
        .push       (push),
        .raw_level  (s_tdata[0]),
        .now_ms     (s_tdata[32:1]),
        .take_short (s_tdata[33]),
        .take_long  (s_tdata[34]),
        .result     (result)
    );

    dtc_out_buf u_out_buf (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (result),
        .ready     (s_tready),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (out_data)
    );

    assign m_tdata = {5'b0, out_data.long_tap, out_data.short_tap, out_data.pressed};

    a_one_tap_kind: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> !(m_tdata[1] && m_tdata[2]))
        else $error("short and long tap flags reported together");

    a_stall_holds_output: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> m_tvalid)
        else $error("input blocked with no pending result");

    a_take_shows_result: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> m_tvalid)
        else $error("accepted poll produced no result");

endmodule

// ----- design/dtc_core.sv -----
// Debounce state, tap classification and configuration registers.
module dtc_core #(
    parameter int TIME_WIDTH = 32
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  cfg_we,
    input  logic [dtc_pkg::CFG_ADDR_WIDTH-1:0]    cfg_addr,
    input  logic [dtc_pkg::CFG_WIDTH-1:0]         cfg_wdata,
    input  logic                                  push,
    input  logic                                  raw_level,
    input  logic [dtc_pkg::STAMP_WIDTH-1:0]       now_ms,
    input  logic                                  take_short,
    input  logic                                  take_long,
    output dtc_pkg::result_t                      result
);

    logic [dtc_pkg::CFG_WIDTH-1:0] debounce_reg;
    logic [dtc_pkg::CFG_WIDTH-1:0] long_tap_reg;

    logic                  prev_raw_reg;
    logic                  level_reg;
    logic                  short_reg;
    logic                  long_reg;
    logic [TIME_WIDTH-1:0] change_time_reg;
    logic [TIME_WIDTH-1:0] press_start_reg;

    logic                  level_next;
    logic                  short_next;
    logic                  long_next;
    logic [TIME_WIDTH-1:0] change_time_next;
    logic [TIME_WIDTH-1:0] press_start_next;

    logic [63:0]           now_wide;
    logic [TIME_WIDTH-1:0] now_t;
    logic [TIME_WIDTH-1:0] steady_time;
    logic [TIME_WIDTH-1:0] hold_time;
    logic                  level_change;

    // Timestamps wrap modulo 2^TIME_WIDTH
    assign now_wide = 64'(now_ms);
    assign now_t    = now_wide[TIME_WIDTH-1:0];

    always_comb
    begin
        change_time_next = (raw_level != prev_raw_reg) ? now_t : change_time_reg;
        steady_time      = now_t - change_time_next;
        hold_time        = now_t - press_start_reg;
        level_change     = (steady_time > TIME_WIDTH'(debounce_reg))
                           && (raw_level != level_reg);
        level_next       = level_reg;
        short_next       = short_reg;
        long_next        = long_reg;
        press_start_next = press_start_reg;
        if (level_change)
        begin
            level_next = raw_level;
            if (raw_level)
            begin
                press_start_next = now_t;
                short_next       = 1'b0;
                long_next        = 1'b0;
            end
            else if (hold_time < TIME_WIDTH'(long_tap_reg))
            begin
                short_next = 1'b1;
            end
            else
            begin
                long_next = 1'b1;
            end
        end
    end

    assign result.pressed   = level_next;
    assign result.short_tap = short_next;
    assign result.long_tap  = long_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            debounce_reg <= dtc_pkg::DEBOUNCE_RESET;
            long_tap_reg <= dtc_pkg::LONG_TAP_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_addr)
                dtc_pkg::REG_DEBOUNCE: debounce_reg <= cfg_wdata;
                dtc_pkg::REG_LONG_TAP: long_tap_reg <= cfg_wdata;
                default:               debounce_reg <= debounce_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_raw_reg    <= 1'b0;
            level_reg       <= 1'b0;
            short_reg       <= 1'b0;
            long_reg        <= 1'b0;
            change_time_reg <= '0;
            press_start_reg <= '0;
        end
        else if (push)
        begin
            prev_raw_reg    <= raw_level;
            level_reg       <= level_next;
            // drop reported flags on request
            short_reg       <= short_next & ~take_short;
            long_reg        <= long_next & ~take_long;
            change_time_reg <= change_time_next;
            press_start_reg <= press_start_next;
        end
    end

endmodule

// ----- design/dtc_out_buf.sv -----
// Output register with a skid stage for the result stream.
module dtc_out_buf (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  dtc_pkg::result_t push_data,
    output logic             ready,
    output logic             out_valid,
    input  logic             out_ready,
    output dtc_pkg::result_t out_data
);

    logic             main_valid_reg;
    logic             skid_valid_reg;
    dtc_pkg::result_t main_data_reg;
    dtc_pkg::result_t skid_data_reg;
    logic             pop;

    assign ready     = ~skid_valid_reg;
    assign out_valid = main_valid_reg;
    assign out_data  = main_data_reg;
    assign pop       = main_valid_reg & out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (skid_valid_reg)
        begin
            if (pop)
            begin
                skid_valid_reg <= 1'b0;
            end
        end
        else if (push)
        begin
            if (main_valid_reg && !pop)
            begin
                skid_valid_reg <= 1'b1;
            end
            main_valid_reg <= 1'b1;
        end
        else if (pop)
        begin
            main_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (skid_valid_reg)
        begin
            if (pop)
            begin
                main_data_reg <= skid_data_reg;
            end
        end
        else if (push)
        begin
            // hold the new item aside while the output stalls
            if (main_valid_reg && !pop)
            begin
                skid_data_reg <= push_data;
            end
            else
            begin
                main_data_reg <= push_data;
            end
        end
    end

endmodule

// ----- dv/tb_debounced_tap_classifier.sv -----
// Testbench for debounced_tap_classifier: timed touch sequences checked against a local predictor.
`timescale 1ns / 100ps

module tb_debounced_tap_classifier;

    localparam int N_PHASES        = 7;
    localparam int POLLS_PER_PHASE = 140;
    localparam int QUIET_LIMIT     = 2000;
    localparam int MAX_REPORTS     = 10;

    // one poll as it sits in s_tdata, highest field first
    typedef struct packed {
        logic                            take_long;
        logic                            take_short;
        logic [dtc_pkg::STAMP_WIDTH-1:0] now_ms;
        logic                            raw_level;
    } poll_t;

    logic                                 clk = 1'b0;
    logic                                 rst_n = 1'b0;
    logic                                 cfg_we = 1'b0;
    logic [dtc_pkg::CFG_ADDR_WIDTH-1:0]   cfg_addr = '0;
    logic [dtc_pkg::CFG_WIDTH-1:0]        cfg_wdata = '0;
    logic                                 s_tvalid = 1'b0;
    logic                                 s_tready;
    // raw_level[0], now_ms[32:1], take_short[33], take_long[34], zero pad
    logic [dtc_pkg::IN_TDATA_WIDTH-1:0]   s_tdata = '0;
    logic                                 m_tvalid;
    logic                                 m_tready = 1'b0;
    // pressed[0], short_tap[1], long_tap[2], zero pad
    logic [dtc_pkg::OUT_TDATA_WIDTH-1:0]  m_tdata;

    // predictor copy of the configuration and the classifier state
    logic [dtc_pkg::CFG_WIDTH-1:0]   debounce_cfg = dtc_pkg::DEBOUNCE_RESET;
    logic [dtc_pkg::CFG_WIDTH-1:0]   long_tap_cfg = dtc_pkg::LONG_TAP_RESET;
    logic                            seen_raw = 1'b0;
    logic                            level_q = 1'b0;
    logic [dtc_pkg::STAMP_WIDTH-1:0] edge_stamp = '0;
    logic [dtc_pkg::STAMP_WIDTH-1:0] press_stamp = '0;
    logic                            short_flag = 1'b0;
    logic                            long_flag = 1'b0;

    poll_t            pending_polls[$];
    dtc_pkg::result_t expected_flags[$];
    poll_t            poll_in_flight;
    logic [dtc_pkg::STAMP_WIDTH-1:0] sim_ms = '0;

    int unsigned polls_queued = 0;
    int unsigned polls_sent = 0;
    int unsigned results_checked = 0;
    int unsigned mismatches = 0;
    int unsigned short_taps = 0;
    int unsigned long_taps = 0;
    int unsigned time_jumps = 0;
    int unsigned settings_run = 1;
    int unsigned send_gap = 0;
    int unsigned stall_left = 0;
    int unsigned calm_left = 0;
    int unsigned quiet_cycles = 0;

    int unsigned phase_debounce[N_PHASES] = '{0, 65535, 3, 0, 65535, 0, 50};
    int unsigned phase_long_tap[N_PHASES] = '{0, 65535, 20, 65535, 0, 0, 1000};

    debounced_tap_classifier uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Advance the classifier by one poll; return the flags as reported, then apply takes.
    function automatic dtc_pkg::result_t classify_poll(input poll_t p);
        logic [dtc_pkg::STAMP_WIDTH-1:0] steady;
        logic [dtc_pkg::STAMP_WIDTH-1:0] held;
        dtc_pkg::result_t                r;
        if (p.raw_level != seen_raw)
            edge_stamp = p.now_ms;
        steady = p.now_ms - edge_stamp;
        if (steady > debounce_cfg && p.raw_level != level_q)
        begin
            level_q = p.raw_level;
            if (p.raw_level)
            begin
                press_stamp = p.now_ms;
                short_flag = 1'b0;
                long_flag = 1'b0;
            end
            else
            begin
                held = p.now_ms - press_stamp;
                if (held < long_tap_cfg)
                begin
                    short_flag = 1'b1;
                    short_taps++;
                end
                else
                begin
                    long_flag = 1'b1;
                    long_taps++;
                end
            end
        end
        seen_raw = p.raw_level;
        r.pressed = level_q;
        r.short_tap = short_flag;
        r.long_tap = long_flag;
        if (p.take_short)
            short_flag = 1'b0;
        if (p.take_long)
            long_flag = 1'b0;
        return r;
    endfunction

    // Mostly back to back, sometimes a short pause, rarely a long one.
    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (calm_left != 0 || r < 65)
            return 0;
        else if (r < 92)
            return $urandom_range(1, 3);
        else
            return $urandom_range(5, 24);
    endfunction

    function automatic logic coin();
        return $urandom_range(0, 4) == 0;
    endfunction

    task automatic queue_poll(input logic raw, input logic [dtc_pkg::STAMP_WIDTH-1:0] stamp,
                              input logic take_s, input logic take_l);
        poll_t p;
        p.raw_level = raw;
        p.now_ms = stamp;
        p.take_short = take_s;
        p.take_long = take_l;
        pending_polls.push_back(p);
        polls_queued++;
    endtask

    // One press and release; the hold lands on, just below or just above the long tap time, or at random.
    task automatic queue_tap();
        int unsigned                     dspan;
        int unsigned                     target;
        int unsigned                     h1;
        int unsigned                     e1;
        int unsigned                     e2;
        int unsigned                     n_mid;
        int unsigned                     k;
        logic [dtc_pkg::STAMP_WIDTH-1:0] t0;
        logic [dtc_pkg::STAMP_WIDTH-1:0] press_at;
        logic [dtc_pkg::STAMP_WIDTH-1:0] rel_at;
        dspan = debounce_cfg + 32'd1;
        case ($urandom_range(0, 4))
            0: target = 32'(long_tap_cfg);
            1: target = (long_tap_cfg != 0) ? long_tap_cfg - 32'd1 : 32'd0;
            2: target = long_tap_cfg + 32'd1;
            default: target = $urandom_range(0, 2 * long_tap_cfg + 20);
        endcase
        e1 = ($urandom_range(0, 3) == 0) ? $urandom_range(0, debounce_cfg + 5) : 0;
        e2 = ($urandom_range(0, 3) == 0) ? $urandom_range(0, debounce_cfg + 5) : 0;
        h1 = (target > dspan + e2) ? target - dspan - e2 : 0;
        // contact bounce: every poll is a level change, so none gets accepted
        repeat ($urandom_range(0, 3))
        begin
            queue_poll(1'b1, sim_ms, coin(), coin());
            sim_ms += $urandom_range(0, 5);
            queue_poll(1'b0, sim_ms, coin(), coin());
            sim_ms += $urandom_range(0, 5);
        end
        t0 = sim_ms + $urandom_range(0, 5);
        queue_poll(1'b1, t0, coin(), coin());
        repeat ($urandom_range(0, 2))
            queue_poll(1'b1, t0 + $urandom_range(0, debounce_cfg), coin(), coin());
        press_at = t0 + dspan + e1;
        queue_poll(1'b1, press_at, coin(), coin());
        n_mid = $urandom_range(0, 4);
        for (k = 1; k <= n_mid; k++)
            queue_poll(($urandom_range(0, 7) == 0) ? 1'b0 : 1'b1,
                       press_at + h1 * k / (n_mid + 1), coin(), coin());
        rel_at = press_at + h1;
        queue_poll(1'b0, rel_at, coin(), coin());
        repeat ($urandom_range(0, 2))
            queue_poll(1'b0, rel_at + $urandom_range(0, debounce_cfg), coin(), coin());
        sim_ms = rel_at + dspan + e2;
        queue_poll(1'b0, sim_ms, coin(), coin());
        repeat ($urandom_range(0, 2))
        begin
            sim_ms += $urandom_range(0, 3 * debounce_cfg + 3);
            queue_poll(1'b0, sim_ms, coin(), coin());
        end
    endtask

    // Random levels and takes; some timestamps jump anywhere, backwards included.
    task automatic queue_noise();
        logic [dtc_pkg::STAMP_WIDTH-1:0] stamp;
        repeat ($urandom_range(1, 4))
        begin
            if ($urandom_range(0, 3) == 0)
            begin
                stamp = $urandom;
                time_jumps++;
                if ($urandom_range(0, 1))
                    sim_ms = stamp;
            end
            else
            begin
                stamp = sim_ms + $urandom_range(0, 2 * debounce_cfg + 2);
                sim_ms = stamp;
            end
            queue_poll(1'($urandom_range(0, 1)), stamp, 1'($urandom_range(0, 1)),
                       1'($urandom_range(0, 1)));
        end
    endtask

    // Hold until every poll is taken and every result has come back.
    task automatic drain();
        do
            @(negedge clk);
        while (pending_polls.size() != 0 || s_tvalid || expected_flags.size() != 0);
    endtask

    task automatic program_reg(input logic [dtc_pkg::CFG_ADDR_WIDTH-1:0] addr,
                               input logic [dtc_pkg::CFG_WIDTH-1:0] value);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_addr <= addr;
        cfg_wdata <= value;
        if (addr == dtc_pkg::REG_DEBOUNCE)
            debounce_cfg = value;
        else
            long_tap_cfg = value;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    // poll sender
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
        end
        else
        begin
            if (s_tvalid && s_tready)
            begin
                expected_flags.push_back(classify_poll(poll_in_flight));
                polls_sent++;
            end
            if (!s_tvalid || s_tready)
            begin
                if (send_gap > 0)
                begin
                    send_gap--;
                    s_tvalid <= 1'b0;
                end
                else if (pending_polls.size() > 0)
                begin
                    poll_in_flight = pending_polls.pop_front();
                    s_tdata <= dtc_pkg::IN_TDATA_WIDTH'(poll_in_flight);
                    s_tvalid <= 1'b1;
                    send_gap = pick_gap();
                end
                else
                begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // result checker and backpressure
    always @(posedge clk)
    begin
        dtc_pkg::result_t want;
        if (!rst_n)
        begin
            m_tready <= 1'b0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                results_checked++;
                if (expected_flags.size() == 0)
                begin
                    if (mismatches < MAX_REPORTS)
                        $display("%t: result with no poll behind it: %b", $realtime, m_tdata);
                    mismatches++;
                end
                else
                begin
                    want = expected_flags.pop_front();
                    if (m_tdata[0] !== want.pressed || m_tdata[1] !== want.short_tap ||
                        m_tdata[2] !== want.long_tap)
                    begin
                        if (mismatches < MAX_REPORTS)
                            $display({"%t: result %0d expected pressed=%b short=%b long=%b,",
                                      " got %b %b %b"},
                                     $realtime, results_checked, want.pressed, want.short_tap,
                                     want.long_tap, m_tdata[0], m_tdata[1], m_tdata[2]);
                        mismatches++;
                    end
                end
            end
            if (stall_left > 0)
            begin
                stall_left--;
                m_tready <= 1'b0;
            end
            else
            begin
                m_tready <= 1'b1;
                stall_left = pick_gap();
            end
        end
    end

    // open stretches with no idling on either side now and then
    always @(negedge clk)
    begin
        if (calm_left > 0)
            calm_left--;
        else if ($urandom_range(0, 199) == 0)
            calm_left = $urandom_range(30, 120);
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("%t: no item moved for %0d cycles, %0d results outstanding",
                         $realtime, quiet_cycles, expected_flags.size());
                $display("TEST FAILED");
                $finish;
            end
        end
    end

    initial
    begin
        int unsigned ph;
        int unsigned phase_end;
        logic        resettle;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // reset settings: debounce edge, wrap, exact long tap boundary, takes, time going back
        queue_poll(1'b0, 32'h0000_0000, 1'b0, 1'b0);
        queue_poll(1'b1, 32'hFFFF_FFC0, 1'b1, 1'b1);
        queue_poll(1'b1, 32'hFFFF_FFF2, 1'b0, 1'b0);
        queue_poll(1'b1, 32'hFFFF_FFF3, 1'b0, 1'b0);
        queue_poll(1'b1, 32'h0000_0100, 1'b1, 1'b0);
        queue_poll(1'b0, 32'h0000_03A8, 1'b0, 1'b0);
        queue_poll(1'b0, 32'h0000_03DB, 1'b0, 1'b0);
        queue_poll(1'b1, 32'h0000_0500, 1'b0, 1'b1);
        queue_poll(1'b1, 32'h0000_0533, 1'b0, 1'b0);
        queue_poll(1'b0, 32'h0000_08E7, 1'b0, 1'b0);
        queue_poll(1'b0, 32'h0000_091A, 1'b0, 1'b0);
        queue_poll(1'b0, 32'h0000_091A, 1'b0, 1'b1);
        queue_poll(1'b0, 32'hFFFF_FFFF, 1'b1, 1'b0);
        queue_poll(1'b0, 32'h0000_0000, 1'b0, 1'b0);
        queue_poll(1'b1, 32'hFFFF_FFFF, 1'b0, 1'b0);
        queue_poll(1'b0, 32'hFFFF_FFFF, 1'b0, 1'b0);
        queue_poll(1'b1, 32'h0000_0040, 1'b0, 1'b0);
        queue_poll(1'b1, 32'h0000_0073, 1'b0, 1'b0);
        queue_poll(1'b0, 32'h0000_0080, 1'b0, 1'b0);
        queue_poll(1'b0, 32'h0000_007F, 1'b0, 1'b0);
        queue_poll(1'b0, 32'h0000_007F, 1'b1, 1'b1);
        drain();

        phase_debounce[5] = $urandom_range(0, 65535);
        phase_long_tap[5] = $urandom_range(0, 65535);
        for (ph = 0; ph < N_PHASES; ph++)
        begin
            program_reg(dtc_pkg::REG_DEBOUNCE, dtc_pkg::CFG_WIDTH'(phase_debounce[ph]));
            program_reg(dtc_pkg::REG_LONG_TAP, dtc_pkg::CFG_WIDTH'(phase_long_tap[ph]));
            settings_run++;
            // start some phases just short of the timestamp wrap
            if ($urandom_range(0, 2) == 0)
                sim_ms = 32'hFFFF_FFFF - $urandom_range(0, 3 * (debounce_cfg + long_tap_cfg) + 100);
            else
                sim_ms = $urandom;
            phase_end = polls_queued + POLLS_PER_PHASE;
            resettle = 1'b1;
            while (polls_queued < phase_end)
            begin
                if ($urandom_range(0, 3) == 0)
                begin
                    queue_noise();
                    resettle = 1'b1;
                end
                else
                begin
                    // drop back to a released level before a clean tap
                    if (resettle)
                    begin
                        queue_poll(1'b0, sim_ms, coin(), coin());
                        sim_ms += debounce_cfg + 32'd1;
                        queue_poll(1'b0, sim_ms, coin(), coin());
                        resettle = 1'b0;
                    end
                    queue_tap();
                end
            end
            drain();
        end

        repeat (8) @(posedge clk);
        $display("Sent %0d polls, checked %0d results over %0d register settings",
                 polls_sent, results_checked, settings_run);
        $display("Predicted %0d short and %0d long taps; %0d polls jumped in time",
                 short_taps, long_taps, time_jumps);
        if (mismatches == 0 && expected_flags.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
